// ===== hdl/gbsp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbsp_pkg
// Phase codes, section codes and helpers for the GIF block stream parser.
// ----------------------------------------------------------------------------
package gbsp_pkg;

	localparam int POS_W = 10;

	localparam logic [3:0] PH_HEADER  = 4'd0;
	localparam logic [3:0] PH_SCREEN  = 4'd1;
	localparam logic [3:0] PH_GLOBAL  = 4'd2;
	localparam logic [3:0] PH_SCAN    = 4'd3;
	localparam logic [3:0] PH_LABEL   = 4'd4;
	localparam logic [3:0] PH_APP     = 4'd5;
	localparam logic [3:0] PH_DATA    = 4'd6;
	localparam logic [3:0] PH_GFX     = 4'd7;
	localparam logic [3:0] PH_IMGDESC = 4'd8;
	localparam logic [3:0] PH_LOCAL   = 4'd9;
	localparam logic [3:0] PH_LZW     = 4'd10;
	localparam logic [3:0] PH_SUBLEN  = 4'd12;
	localparam logic [3:0] PH_HALT    = 4'd15;

	localparam logic [3:0] SEC_HEADER  = 4'd0;
	localparam logic [3:0] SEC_SCREEN  = 4'd1;
	localparam logic [3:0] SEC_GLOBAL  = 4'd2;
	localparam logic [3:0] SEC_SCAN    = 4'd3;
	localparam logic [3:0] SEC_LABEL   = 4'd4;
	localparam logic [3:0] SEC_APP     = 4'd5;
	localparam logic [3:0] SEC_EXTDATA = 4'd6;
	localparam logic [3:0] SEC_GFX     = 4'd7;
	localparam logic [3:0] SEC_IMGDESC = 4'd8;
	localparam logic [3:0] SEC_LOCAL   = 4'd9;
	localparam logic [3:0] SEC_LZW     = 4'd10;
	localparam logic [3:0] SEC_IMGDATA = 4'd11;
	localparam logic [3:0] SEC_SUBLEN  = 4'd12;
	localparam logic [3:0] SEC_TERM    = 4'd13;
	localparam logic [3:0] SEC_TRAILER = 4'd14;
	localparam logic [3:0] SEC_HALT    = 4'd15;

	localparam logic [1:0] KIND_APP     = 2'd0;
	localparam logic [1:0] KIND_COMMENT = 2'd1;
	localparam logic [1:0] KIND_IMAGE   = 2'd2;

	localparam logic [7:0] BYTE_TRAILER = 8'h3B;
	localparam logic [7:0] BYTE_EXT     = 8'h21;
	localparam logic [7:0] BYTE_IMAGE   = 8'h2C;
	localparam logic [7:0] LABEL_APP    = 8'hFF;
	localparam logic [7:0] LABEL_CMT    = 8'hFE;
	localparam logic [7:0] LABEL_GFX    = 8'hF9;

	localparam logic [POS_W-1:0] LEN_HEADER  = 10'd6;
	localparam logic [POS_W-1:0] LEN_SCREEN  = 10'd7;
	localparam logic [POS_W-1:0] LEN_APP     = 10'd12;
	localparam logic [POS_W-1:0] LEN_GFX     = 10'd6;
	localparam logic [POS_W-1:0] LEN_IMGDESC = 10'd10;
	localparam logic [POS_W-1:0] POS_PACKED_SCR = 10'd4;
	localparam logic [POS_W-1:0] POS_PACKED_IMG = 10'd9;

	// "GIF89a"
	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0:    r = 8'h47;
			3'd1:    r = 8'h49;
			3'd2:    r = 8'h46;
			3'd3:    r = 8'h38;
			3'd4:    r = 8'h39;
			3'd5:    r = 8'h61;
			default: r = 8'h47;
		endcase
		return r;
	endfunction

	function automatic logic [POS_W-1:0] table_bytes(input logic [7:0] packed_b);
		logic [3:0] sh;
		sh = {1'b0, packed_b[2:0]} + 4'd1;
		if (!packed_b[7])
			return '0;
		return POS_W'(10'd3 << sh);
	endfunction

endpackage

// ===== hdl/gif_block_stream_parser_top.sv =====
// ----------------------------------------------------------------------------
// gif_block_stream_parser_top
// Labels each byte of a GIF89a file with its section and position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: data_byte and start_of_file with in_valid / in_stall.
//   An item is taken on a clock edge with in_valid high and in_stall low.
//   Raise start_of_file on the first byte of every file.
//   Output channel: one result item per input item, on section, byte_value,
//   offset_in_section, section_end, frames_seen, format_error and
//   trailer_seen with out_valid / out_stall.
//   An input register, then the parse step into the result register;
//   out_valid rises once the parse step has written the result register.
//   Throughput is one item per cycle while the receiver does not stall,
//   set by the combinational phase and counter update.
//   While the receiver stalls, the result holds; the input register still
//   fills once, after which in_stall rises until the result is taken.
//   Reset clears both stage valids and returns the parser to the header
//   phase with all counters and flags cleared.
// ----------------------------------------------------------------------------
module gif_block_stream_parser_top
	import gbsp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             start_of_file,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [3:0]       section,
	output logic [7:0]       byte_value,
	output logic [POS_W-1:0] offset_in_section,
	output logic             section_end,
	output logic [15:0]      frames_seen,
	output logic             format_error,
	output logic             trailer_seen
);

	logic             valid_s1, sof_s1;
	logic [7:0]       data_s1;
	logic             valid_s2;
	logic [3:0]       sec_s2;
	logic [7:0]       byte_s2;
	logic [POS_W-1:0] off_s2;
	logic             end_s2;

	logic [3:0]       phase_q;
	logic [POS_W-1:0] pos_q, slen_q;
	logic [7:0]       sbl_q;
	logic [1:0]       kind_q;
	logic             mism_q, fin_q;
	logic [15:0]      cnt_q;

	logic             hold_s2, hold_s1, step;

	logic [3:0]       ph, n_ph;
	logic [POS_W-1:0] pos, n_pos, slen, n_slen;
	logic [7:0]       sbl, n_sbl;
	logic [1:0]       kind, n_kind;
	logic             mism, n_mism, fin, n_fin;
	logic [15:0]      cnt, n_cnt;
	logic [3:0]       sec;
	logic [POS_W-1:0] off;
	logic             s_end;
	logic [POS_W:0]   pos_inc;
	logic [7:0]       b;

	assign hold_s2  = valid_s2 && out_stall;
	assign hold_s1  = valid_s1 && hold_s2;
	assign in_stall = hold_s1;
	assign step     = valid_s1 && !hold_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold_s1 && in_valid) begin
			data_s1 <= data_byte;
			sof_s1  <= start_of_file;
		end
	end

	always_comb begin
		b       = data_s1;
		ph      = sof_s1 ? PH_HEADER : phase_q;
		pos     = sof_s1 ? '0 : pos_q;
		slen    = sof_s1 ? '0 : slen_q;
		sbl     = sof_s1 ? '0 : sbl_q;
		kind    = sof_s1 ? KIND_APP : kind_q;
		mism    = sof_s1 ? 1'b0 : mism_q;
		fin     = sof_s1 ? 1'b0 : fin_q;
		cnt     = sof_s1 ? '0 : cnt_q;
		pos_inc = {1'b0, pos} + 1'b1;

		n_ph   = ph;
		n_pos  = pos;
		n_slen = slen;
		n_sbl  = sbl;
		n_kind = kind;
		n_mism = mism;
		n_fin  = fin;
		n_cnt  = cnt;
		sec    = SEC_HALT;
		off    = '0;
		s_end  = 1'b0;

		case (ph)
			PH_HEADER: begin
				sec = SEC_HEADER;
				off = pos;
				if (b != sig_byte(pos[2:0]))
					n_mism = 1'b1;
				if (pos_inc >= {1'b0, LEN_HEADER}) begin
					s_end = 1'b1;
					n_pos = '0;
					n_ph  = n_mism ? PH_HALT : PH_SCREEN;
				end else begin
					n_pos = pos_inc[POS_W-1:0];
				end
			end
			PH_SCREEN: begin
				sec = SEC_SCREEN;
				off = pos;
				if (pos == POS_PACKED_SCR)
					n_slen = table_bytes(b);
				if (pos_inc >= {1'b0, LEN_SCREEN}) begin
					s_end = 1'b1;
					n_pos = '0;
					n_ph  = (n_slen != '0) ? PH_GLOBAL : PH_SCAN;
				end else begin
					n_pos = pos_inc[POS_W-1:0];
				end
			end
			PH_GLOBAL, PH_LOCAL: begin
				sec = (ph == PH_GLOBAL) ? SEC_GLOBAL : SEC_LOCAL;
				off = pos;
				if (pos_inc >= {1'b0, slen}) begin
					s_end = 1'b1;
					n_pos = '0;
					n_ph  = (ph == PH_GLOBAL) ? PH_SCAN : PH_LZW;
				end else begin
					n_pos = pos_inc[POS_W-1:0];
				end
			end
			PH_SCAN: begin
				if (b == BYTE_TRAILER) begin
					sec   = SEC_TRAILER;
					s_end = 1'b1;
					n_fin = 1'b1;
					n_ph  = PH_HALT;
				end else if (b == BYTE_EXT) begin
					sec   = SEC_LABEL;
					n_pos = 10'd1;
					n_ph  = PH_LABEL;
				end else if (b == BYTE_IMAGE) begin
					sec    = SEC_IMGDESC;
					n_pos  = 10'd1;
					n_slen = '0;
					n_ph   = PH_IMGDESC;
				end else begin
					sec   = SEC_SCAN;
					s_end = 1'b1;
				end
			end
			PH_LABEL: begin
				sec   = SEC_LABEL;
				off   = 10'd1;
				s_end = 1'b1;
				n_pos = '0;
				if (b == LABEL_APP) begin
					n_kind = KIND_APP;
					n_ph   = PH_APP;
				end else if (b == LABEL_CMT) begin
					n_kind = KIND_COMMENT;
					n_ph   = PH_SUBLEN;
				end else if (b == LABEL_GFX) begin
					n_ph = PH_GFX;
				end else begin
					n_ph = PH_SCAN;
				end
			end
			PH_APP, PH_GFX: begin
				sec = (ph == PH_APP) ? SEC_APP : SEC_GFX;
				off = pos;
				if (pos_inc >= {1'b0, ((ph == PH_APP) ? LEN_APP : LEN_GFX)}) begin
					s_end = 1'b1;
					n_pos = '0;
					n_ph  = (ph == PH_APP) ? PH_SUBLEN : PH_SCAN;
				end else begin
					n_pos = pos_inc[POS_W-1:0];
				end
			end
			PH_IMGDESC: begin
				sec = SEC_IMGDESC;
				off = pos;
				if (pos == POS_PACKED_IMG)
					n_slen = table_bytes(b);
				if (pos_inc >= {1'b0, LEN_IMGDESC}) begin
					s_end = 1'b1;
					n_pos = '0;
					n_ph  = (n_slen != '0) ? PH_LOCAL : PH_LZW;
				end else begin
					n_pos = pos_inc[POS_W-1:0];
				end
			end
			PH_LZW: begin
				sec    = SEC_LZW;
				s_end  = 1'b1;
				n_kind = KIND_IMAGE;
				n_pos  = '0;
				n_ph   = PH_SUBLEN;
			end
			PH_SUBLEN: begin
				s_end = 1'b1;
				n_pos = '0;
				if (b == 8'd0) begin
					sec  = SEC_TERM;
					n_ph = PH_SCAN;
					if (kind == KIND_IMAGE && cnt != 16'hFFFF)
						n_cnt = cnt + 16'd1;
				end else begin
					sec   = SEC_SUBLEN;
					n_sbl = b;
					n_ph  = PH_DATA;
				end
			end
			PH_DATA: begin
				sec = (kind == KIND_IMAGE) ? SEC_IMGDATA : SEC_EXTDATA;
				off = pos;
				if (sbl <= 8'd1) begin
					s_end = 1'b1;
					n_sbl = '0;
					n_pos = '0;
					n_ph  = PH_SUBLEN;
				end else begin
					n_sbl = sbl - 8'd1;
					n_pos = pos_inc[POS_W-1:0];
				end
			end
			default: begin
				sec = SEC_HALT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			slen_q   <= '0;
			sbl_q    <= '0;
			kind_q   <= KIND_APP;
			mism_q   <= 1'b0;
			fin_q    <= 1'b0;
			cnt_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (!hold_s2)
				valid_s2 <= valid_s1;
			if (step) begin
				phase_q <= n_ph;
				pos_q   <= n_pos;
				slen_q  <= n_slen;
				sbl_q   <= n_sbl;
				kind_q  <= n_kind;
				mism_q  <= n_mism;
				fin_q   <= n_fin;
				cnt_q   <= n_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			sec_s2  <= sec;
			byte_s2 <= b;
			off_s2  <= off;
			end_s2  <= s_end;
		end
	end

	assign out_valid         = valid_s2;
	assign section           = sec_s2;
	assign byte_value        = byte_s2;
	assign offset_in_section = off_s2;
	assign section_end       = end_s2;
	assign frames_seen       = cnt_q;
	assign format_error      = mism_q;
	assign trailer_seen      = fin_q;

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with no item held");

	a_trailer_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && section == SEC_TRAILER) |-> trailer_seen)
		else $error("trailer labelled without trailer flag");

	a_halt_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && section == SEC_HALT) |-> (offset_in_section == '0 && !section_end))
		else $error("error section with offset or end set");

	a_header_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_SCREEN && !sof_s1) |-> !mism_q)
		else $error("screen descriptor reached after header mismatch");
`endif

endmodule
